/* design/tcf_pkg.sv */
`default_nettype none
package tcf_pkg;

  // cordic iteration count and iteration counter width
  localparam int CORDIC_STEPS = 16;
  localparam int IterW = 5;
  localparam logic [IterW-1:0] LAST_ITER = IterW'(CORDIC_STEPS - 1);

  // gyro step divisor 128000000 = 15625 * 2^13, reciprocal of 15625 scaled by 2^45
  localparam logic [13:0] DIV_ODD   = 14'd15625;
  localparam logic [31:0] DIV_RECIP = 32'd2251799813;

  // configuration register indexes
  localparam logic [0:0] CFG_GYRO_WEIGHT = 1'b0;
  localparam logic [0:0] CFG_GYRO_FS     = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CSETUP,
    ST_CITER,
    ST_CFIN,
    ST_MUL1,
    ST_MUL2,
    ST_DSET,
    ST_RECIP,
    ST_RSUB,
    ST_DIV,
    ST_PRED,
    ST_BLEND1,
    ST_BLEND2,
    ST_OUT
  } state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_q16(input logic [IterW-1:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // saturate to +/-180 degrees in 1/256 degree
  function automatic logic signed [16:0] clamp_ang(input logic signed [33:0] v);
    logic signed [16:0] r;
    if (v > 34'sd46080) r = 17'sd46080;
    else if (v < -34'sd46080) r = -17'sd46080;
    else r = v[16:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/tilt_complementary_filter_top.sv */
`default_nettype none
// Tilt estimator: complementary filter for roll and pitch.
// Input channel (in_valid / in_stall) takes one IMU sample: accel X/Y/Z,
// gyro X/Y and a microsecond timestamp. Result channel (out_valid /
// out_stall) gives one roll/pitch pair in 1/256 degree per sample.
// One shared sequencer handles roll, then pitch. Per axis: 16 CORDIC
// iterations, multiply states ST_MUL1 and ST_MUL2, a gyro step divide by
// 128000000 done as a reciprocal multiply and a subtract correction, and
// blend states ST_BLEND1 and ST_BLEND2; a zero accel Y (roll) or X
// (pitch) component skips the CORDIC. in_stall is high until the result
// is loaded and drops in the idle state after it, so a new sample is taken
// only then; the shared CORDIC loop sets most of the time per sample.
// The finished result sits in an output register; while the receiver
// stalls it holds, and the next sample is already taken and worked on;
// a second finished result waits with in_stall high until the first goes.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only
// while idle; the block itself does not enforce this.
// Synchronous reset restores weight 205, full scale 2000, zero estimates,
// and marks the next sample as first (no gyro contribution).
module tilt_complementary_filter_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [10:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_gyro_x,
  input  wire logic signed [15:0] in_gyro_y,
  input  wire logic [31:0]        in_timestamp_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      out_roll_angle,
  output logic signed [16:0]      out_pitch_angle
);
  import tcf_pkg::*;

  state_t state_r, state_nxt;

  logic [8:0]  gw_r;
  logic [10:0] fs_r;
  logic [31:0] last_ts_r;
  logic        have_last_r;
  logic signed [16:0] roll_r, pitch_r;
  logic        out_valid_r;
  logic signed [16:0] out_roll_r, out_pitch_r;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [31:0] dt_r;
  logic        axis_r;
  logic signed [33:0] x_r, y_r;
  logic signed [26:0] a_r;
  logic [IterW-1:0] i_r;
  logic signed [16:0] acc_r, pred_r;
  logic signed [27:0] prod_r;
  logic signed [60:0] p_r;
  logic [45:0] n_r;
  logic [16:0] rem_r;
  logic [31:0] q_r;
  logic        neg_r;
  logic signed [26:0] t_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // per-axis operand selection
  logic signed [15:0] sel_y, sel_g;
  logic signed [16:0] sel_est;
  assign sel_y   = axis_r ? ax_r : ay_r;
  assign sel_g   = axis_r ? gy_r : gx_r;
  assign sel_est = axis_r ? pitch_r : roll_r;

  // cordic step terms
  logic signed [33:0] dx, dy, zx;
  logic signed [26:0] atan_s, a_rnd;
  logic               y_pos;
  assign dx     = y_r >>> i_r;
  assign dy     = x_r >>> i_r;
  assign atan_s = $signed({5'b0, atan_q16(i_r)});
  assign y_pos  = !y_r[33] && (y_r != 34'sd0);
  assign zx     = 34'(az_r);
  assign a_rnd  = (a_r + 27'sd128) >>> 8;

  // divide and blend terms
  logic signed [60:0] p_mag;
  logic [58:0]        n_full;
  logic [63:0]        recip_prod;
  logic [45:0]        qd;
  logic signed [33:0] delta, pred_sum;
  logic [8:0]         w;
  logic [8:0]         w_inv;
  logic signed [27:0] mix;
  logic signed [16:0] blend_res;
  assign p_mag    = p_r[60] ? -p_r : p_r;
  assign n_full   = p_mag[58:0] + 59'd64000000;
  assign recip_prod = 64'(n_r[45:14]) * 64'(DIV_RECIP);
  assign qd       = 46'(q_r) * 46'(DIV_ODD);
  assign delta    = neg_r ? -$signed({2'b0, q_r}) : $signed({2'b0, q_r});
  assign pred_sum = 34'(sel_est) + delta;
  assign w        = (gw_r > 9'd256) ? 9'd256 : gw_r;
  assign w_inv    = 9'(10'd256 - {1'b0, w});
  assign mix      = 28'(t_r) + $signed({1'b0, w_inv}) * acc_r + 28'sd128;
  assign blend_res = clamp_ang(34'(mix >>> 8));

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_CSETUP;
      ST_CSETUP: state_nxt = (sel_y == 16'sd0) ? ST_MUL1 : ST_CITER;
      ST_CITER:  if (i_r == LAST_ITER) state_nxt = ST_CFIN;
      ST_CFIN:   state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_DSET;
      ST_DSET:   state_nxt = ST_RECIP;
      ST_RECIP:  state_nxt = ST_RSUB;
      ST_RSUB:   state_nxt = ST_DIV;
      ST_DIV:    if (rem_r < {3'b0, DIV_ODD}) state_nxt = ST_PRED;
      ST_PRED:   state_nxt = ST_BLEND1;
      ST_BLEND1: state_nxt = ST_BLEND2;
      ST_BLEND2: state_nxt = axis_r ? ST_OUT : ST_CSETUP;
      ST_OUT:    if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state, configuration and estimates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gw_r        <= 9'd205;
      fs_r        <= 11'd2000;
      last_ts_r   <= '0;
      have_last_r <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GYRO_WEIGHT: gw_r <= cfg_wdata[8:0];
          CFG_GYRO_FS:     fs_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        last_ts_r   <= in_timestamp_us;
        have_last_r <= 1'b1;
        axis_r      <= 1'b0;
      end
      if (state_r == ST_BLEND2) begin
        if (axis_r) pitch_r <= blend_res;
        else        roll_r  <= blend_res;
        axis_r <= 1'b1;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  // shared datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
      dt_r <= have_last_r ? (in_timestamp_us - last_ts_r) : 32'd0;
    end
    case (state_r)
      ST_CSETUP: begin
        i_r <= '0;
        if (sel_y == 16'sd0) begin
          acc_r <= az_r[15] ? 17'sd46080 : 17'sd0;
        end else if (az_r[15]) begin
          a_r <= (sel_y > 16'sd0) ? 27'sd11796480 : -27'sd11796480;
          x_r <= (-zx) <<< 14;
          y_r <= (-34'(sel_y)) <<< 14;
        end else begin
          a_r <= '0;
          x_r <= zx <<< 14;
          y_r <= 34'(sel_y) <<< 14;
        end
      end
      ST_CITER: begin
        i_r <= i_r + 1'b1;
        if (y_pos) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          a_r <= a_r + atan_s;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          a_r <= a_r - atan_s;
        end
      end
      ST_CFIN: acc_r <= clamp_ang(34'(a_rnd));
      ST_MUL1: prod_r <= sel_g * $signed({1'b0, fs_r});
      ST_MUL2: p_r <= prod_r * $signed({1'b0, dt_r});
      ST_DSET: begin
        // rounded magnitude, power-of-two part of the divisor dropped
        neg_r <= p_r[60];
        n_r   <= n_full[58:13];
        q_r   <= '0;
      end
      // quotient estimate from the reciprocal, at most four short
      ST_RECIP: q_r <= recip_prod[62:31];
      ST_RSUB:  rem_r <= 17'(n_r - qd);
      ST_DIV: begin
        // compare and subtract until the remainder is below the divisor
        if (rem_r >= {3'b0, DIV_ODD}) begin
          rem_r <= rem_r - {3'b0, DIV_ODD};
          q_r   <= q_r + 32'd1;
        end
      end
      ST_PRED:   pred_r <= clamp_ang(pred_sum);
      ST_BLEND1: t_r <= $signed({1'b0, w}) * pred_r;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_roll_r  <= roll_r;
          out_pitch_r <= pitch_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;

  // checks
  a_first_dt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !have_last_r |=> dt_r == 32'd0) else $error("first sample dt not zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CSETUP && !axis_r) else $error("sequencer did not start");
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("result without sequence");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_roll_r <= 17'sd46080 && out_roll_r >= -17'sd46080
      && out_pitch_r <= 17'sd46080 && out_pitch_r >= -17'sd46080)
    else $error("angle out of range");

endmodule
`default_nettype wire
